FILE: rtl/core/pplp_pkg.sv
// Shared types and constants for the polyline projection block.
package pplp_pkg;

  localparam int unsigned CoordW = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDA   = 13'b0000000000010,
    S_RDB   = 13'b0000000000100,
    S_LOAD  = 13'b0000000001000,
    S_DOT   = 13'b0000000010000,
    S_PREP  = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_PROJ  = 13'b0000010000000,
    S_DIST  = 13'b0000100000000,
    S_CMP   = 13'b0001000000000,
    S_SQRT  = 13'b0010000000000,
    S_OUT   = 13'b0100000000000,
    S_MULT  = 13'b1000000000000
  } state_t;

endpackage

FILE: rtl/core/point_to_polyline_projection_top.sv
// Top level of the closest-point-on-polyline block.
//
// Usage: one slave stream carries commands, one master stream carries
// results. s_tuser holds func (0 clear, 1 append, 2 query). s_tdata
// holds coord_x in [31:0] and coord_y in [63:32], signed Q16.16.
// Clear and append beats produce no result; a query produces exactly one
// result beat: m_tdata = {dist_res, closest_y, closest_x}, m_tuser = found.
//
// Clear and append complete in the idle state. A query walks the stored
// segments one at a time through one shared 34x34 signed multiplier and a
// restoring divider that yields one quotient bit a cycle; a segment skips
// the divide when t needs none. The final vertex reads are followed by a
// bit-serial square root, after which the result beat is offered.
// The vertex store has registered read data, so each segment reads its two
// vertices in turn. s_tready is high only while the block is idle.
//
// Reset clears the vertex count and the sequencer; the vertex store keeps
// its contents; reads past the count go unused. When the receiver stalls,
// hold the result beat in the output register and accept no new command.
module point_to_polyline_projection_top #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [63:0]            s_tdata,   // coord_x [31:0], coord_y [63:32]
  input  logic [1:0]             s_tuser,   // func [1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [95:0]            m_tdata,   // closest_x, closest_y, dist_res
  output logic                   m_tuser    // found
);
  import pplp_pkg::*;

  localparam int unsigned IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  // vertex memory, both coordinates in one word
  logic [63:0] vmem [MAX_VERTICES];
  logic [63:0] vrd;
  logic        vwe;
  logic [IdxW-1:0] vaddr;

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vaddr] <= s_tdata;
    end
    vrd <= vmem[vaddr];
  end

  state_t state;
  logic [CntW-1:0] count, seg;
  logic signed [32:0] px, py, ax, ay, abx, aby, pax, pay;
  logic signed [32:0] bx, by, qx, qy;
  logic        have;
  logic [65:0] best;
  logic [65:0] acc;
  logic [65:0] den, num;
  logic [16:0] t;
  logic [4:0]  step;
  logic [2:0]  mstep;
  // shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  // square root
  logic [63:0] sq_n, sq_res;
  logic [63:0] sq_bit;

  assign mp = ma * mb;
  assign s_tready = (state == S_IDLE);
  assign vwe = (state == S_IDLE) && s_tvalid && (func_t'(s_tuser) == FUNC_APPEND)
               && (count < CntW'(MAX_VERTICES));

  always_comb begin
    vaddr = count[IdxW-1:0];
    if (state == S_RDA) vaddr = seg[IdxW-1:0];
    else if (state == S_RDB) vaddr = IdxW'(seg + 1'b1);
  end

  logic [66:0] dsub;
  assign dsub = {num, 1'b0} - {1'b0, den};

  // t*ab with floor division by 65536 is an arithmetic shift
  logic [1:0] mphase;

  logic [63:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            case (func_t'(s_tuser))
              FUNC_CLEAR:  count <= '0;
              FUNC_APPEND: if (count < CntW'(MAX_VERTICES)) count <= count + 1'b1;
              FUNC_QUERY: begin
                px    <= {s_tdata[31], s_tdata[31:0]};
                py    <= {s_tdata[63], s_tdata[63:32]};
                have  <= 1'b0;
                seg   <= '0;
                bx    <= '0;
                by    <= '0;
                state <= S_RDA;
              end
              default: ;
            endcase
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          // vrd now holds vertex seg; capture it as the first vertex
          ax <= {vrd[31], vrd[31:0]};
          ay <= {vrd[63], vrd[63:32]};
          if (seg == '0 && count != '0) begin
            bx <= {vrd[31], vrd[31:0]};
            by <= {vrd[63], vrd[63:32]};
          end
          if (CntW'(seg + 1'b1) >= count) state <= S_SQRT;
          else state <= S_LOAD;
          sq_res <= '0;
          sq_n   <= best[63:0];
          sq_bit <= 64'h4000_0000_0000_0000;
        end
        S_LOAD: begin
          abx <= 33'(signed'({vrd[31], vrd[31:0]}) - ax);
          aby <= 33'(signed'({vrd[63], vrd[63:32]}) - ay);
          pax <= px - ax;
          pay <= py - ay;
          mstep <= '0;
          state <= S_MULT;
        end
        S_MULT: begin
          // four products through one multiplier: abx^2, aby^2, pax*abx, pay*aby
          mstep <= mstep + 1'b1;
          case (mstep)
            3'd0: den <= 66'(mp);
            3'd1: den <= den + 66'(mp);
            3'd2: acc <= 66'(mp);
            3'd3: begin
              state <= S_PREP;
            end
            default: ;
          endcase
        end
        S_PREP: begin
          // acc = pax*abx, mp = pay*aby
          t <= '0;
          if (den != '0 && signed'({acc[65], acc} + {mp[65], 66'(mp)}) > 0) begin
            num <= acc + 66'(mp);
            if (acc + 66'(mp) >= den) begin
              t     <= 17'h10000;
              mphase <= '0;
              state <= S_PROJ;
            end else begin
              step  <= '0;
              state <= S_DIV;
            end
          end else begin
            mphase <= '0;
            state <= S_PROJ;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (!dsub[66]) begin
            num <= dsub[65:0];
            t   <= {t[15:0], 1'b1};
          end else begin
            num <= {num[64:0], 1'b0};
            t   <= {t[15:0], 1'b0};
          end
          if (step == 5'd15) begin
            mphase <= '0;
            state  <= S_PROJ;
          end
        end
        S_PROJ: begin
          mphase <= mphase + 1'b1;
          case (mphase)
            2'd0: qx <= 33'(ax + (mp >>> 16));
            2'd1: begin
              qy <= 33'(ay + (mp >>> 16));
              mstep <= '0;
              state <= S_DIST;
            end
            default: ;
          endcase
        end
        S_DIST: begin
          mstep <= mstep + 1'b1;
          case (mstep)
            3'd0: acc <= 66'(mp);
            3'd1: begin
              acc <= acc + 66'(mp);
              state <= S_CMP;
            end
            default: ;
          endcase
        end
        S_CMP: begin
          if (!have || acc < best) begin
            have <= 1'b1;
            best <= acc;
            bx   <= qx;
            by   <= qy;
          end
          seg   <= seg + 1'b1;
          state <= S_RDA;
        end
        S_SQRT: begin
          // one result bit a cycle, remainder kept in sq_n
          if (sq_n >= sq_try) begin
            sq_n   <= sq_n - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(!have || best[65:64] != '0) ? 32'hFFFF_FFFF : sq_res[31:0],
                         by[31:0], bx[31:0]};
            m_tuser  <= have;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_MULT || state == S_PREP) begin
      case (mstep)
        3'd0: begin ma = 34'(abx); mb = 34'(abx); end
        3'd1: begin ma = 34'(aby); mb = 34'(aby); end
        3'd2: begin ma = 34'(pax); mb = 34'(abx); end
        default: begin ma = 34'(pay); mb = 34'(aby); end
      endcase
    end else if (state == S_PROJ) begin
      ma = signed'({17'd0, t});
      mb = (mphase == 2'd0) ? 34'(abx) : 34'(aby);
    end else if (state == S_DIST) begin
      ma = (mstep == 3'd0) ? 34'(px - qx) : 34'(py - qy);
      mb = ma;
    end
  end

endmodule
